// ===== hw/rtl/dscs_pkg.sv =====
// dscs_pkg: types, codes and constants shared by the device scan and command sequencer.
// No dependencies; every other file of the block imports it.
package dscs_pkg;

    localparam int MAX_DEVICES = 16;

    localparam int RETRY_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int TIMEOUT_W = 16;
    localparam int DEV_W     = 4;
    localparam int MASK_W    = 16;
    localparam int ELAPSED_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST  = RETRY_W'(3);
    localparam logic [COUNT_W-1:0]   DEVICE_COUNT_RST = COUNT_W'(10);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST   = TIMEOUT_W'(200);
    localparam logic [COUNT_W-1:0]   MAX_DEVICES_C    = COUNT_W'(MAX_DEVICES);
    localparam logic [RETRY_W-1:0]   RETRY_MAX        = '1;
    localparam logic [TIMEOUT_W-1:0] TIMER_MAX        = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RETRY_LIMIT  = 2'd0,
        REG_DEVICE_COUNT = 2'd1,
        REG_TIMEOUT_MS   = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SCAN  = 2'd1,
        FUNC_SEND  = 2'd2,
        FUNC_SPARE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_BUSY  = 3'd1,
        EV_LOST  = 3'd2,
        EV_SENT  = 3'd3,
        EV_RECV  = 3'd4,
        EV_RSVD5 = 3'd5,
        EV_RSVD6 = 3'd6,
        EV_RSVD7 = 3'd7
    } radio_ev_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SCAN = 2'd1,
        MODE_SEND = 2'd2
    } hub_mode_t;

    typedef enum logic [2:0] {
        SS_IDLE  = 3'd0,
        SS_START = 3'd1,
        SS_SEND  = 3'd2,
        SS_WAIT  = 3'd3,
        SS_LOST  = 3'd4,
        SS_FOUND = 3'd5
    } scan_step_t;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [RETRY_W-1:0]   retry_limit;
        logic [COUNT_W-1:0]   device_count;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [2:0]           radio_event;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 reply_is_status;
        logic [DEV_W-1:0]     device_index;
        logic                 message_kind;
        logic [1:0]           command_code;
    } item_t;

    typedef struct packed {
        hub_mode_t            mode;
        scan_step_t           scan_step;
        logic [COUNT_W-1:0]   scan_index;
        logic [RETRY_W-1:0]   retries;
        logic [TIMEOUT_W-1:0] reply_timer;
        logic [MASK_W-1:0]    responders;
        logic [DEV_W-1:0]     selected_target;
    } hub_state_t;

    typedef struct packed {
        logic              send_valid;
        logic [DEV_W-1:0]  send_target;
        logic              send_kind;
        logic [1:0]        send_command;
        logic              busy_reject;
        logic              scan_done;
        logic [MASK_W-1:0] found_mask;
        logic              status_received;
        logic              timed_out;
        logic [1:0]        hub_mode;
    } result_t;

endpackage

// ===== hw/rtl/device_scan_and_command_sequencer.sv =====
// device_scan_and_command_sequencer: top level of the radio hub scan/command sequencer.
// Depends on dscs_pkg, dscs_cfg and dscs_step.
//
//  channel   handshake             payload
//  -------   -------------------   ----------------------------------------------
//  in        in_valid / in_ready   func radio_event elapsed_ms reply_is_status
//                                  device_index message_kind command_code
//  out       out_valid / out_ready send_valid send_target send_kind send_command
//                                  busy_reject scan_done found_mask status_received
//                                  timed_out hub_mode
//  cfg       cfg_we (no wait)      cfg_index cfg_data
//
// One word per clock while out_ready stays high; each word passes the input register, then the result register.
// The step is a single pass of dscs_step between the input register and the result
// register; hub state updates on the edge at which the result is loaded.
// Reset (rst_n, async, active low) empties both registers, idles the hub and restores
// the configuration defaults.
// A stalled output holds its word; the input register keeps one word behind it, then
// in_ready drops until out_ready returns.
module device_scan_and_command_sequencer
    import dscs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [2:0]            radio_event,
    input  logic [ELAPSED_W-1:0]  elapsed_ms,
    input  logic                  reply_is_status,
    input  logic [DEV_W-1:0]      device_index,
    input  logic                  message_kind,
    input  logic [1:0]            command_code,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  send_valid,
    output logic [DEV_W-1:0]      send_target,
    output logic                  send_kind,
    output logic [1:0]            send_command,
    output logic                  busy_reject,
    output logic                  scan_done,
    output logic [MASK_W-1:0]     found_mask,
    output logic                  status_received,
    output logic                  timed_out,
    output logic [1:0]            hub_mode,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    item_t      item_reg;
    logic       item_valid_reg;
    hub_state_t state_reg;
    hub_state_t state_next;
    result_t    result_next;
    result_t    result_reg;
    logic       out_valid_reg;
    logic       advance;

    dscs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dscs_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // step fires when a word waits and the result slot is free or draining
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.func            <= func;
            item_reg.radio_event     <= radio_event;
            item_reg.elapsed_ms      <= elapsed_ms;
            item_reg.reply_is_status <= reply_is_status;
            item_reg.device_index    <= device_index;
            item_reg.message_kind    <= message_kind;
            item_reg.command_code    <= command_code;
        end
    end

    // hub state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode            <= MODE_IDLE;
            state_reg.scan_step       <= SS_IDLE;
            state_reg.scan_index      <= '0;
            state_reg.retries         <= '0;
            state_reg.reply_timer     <= '0;
            state_reg.responders      <= '0;
            state_reg.selected_target <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign send_valid      = result_reg.send_valid;
    assign send_target     = result_reg.send_target;
    assign send_kind       = result_reg.send_kind;
    assign send_command    = result_reg.send_command;
    assign busy_reject     = result_reg.busy_reject;
    assign scan_done       = result_reg.scan_done;
    assign found_mask      = result_reg.found_mask;
    assign status_received = result_reg.status_received;
    assign timed_out       = result_reg.timed_out;
    assign hub_mode        = result_reg.hub_mode;

    // scan sub-step only runs while the hub is scanning
    a_scan_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode != MODE_SCAN) |-> (state_reg.scan_step == SS_IDLE))
        else $error("scan sub-step active outside scan mode");

    // a waiting word that cannot step is held in place
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input word lost while result stalled");

    // every step lands in the result register
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step fired without loading a result");

    // a transmitted message is never also a refusal, a timeout or a scan end
    a_send_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.send_valid) |->
        (!result_reg.busy_reject && !result_reg.timed_out && !result_reg.scan_done))
        else $error("send flagged together with reject, timeout or scan end");

    // end of scan always leaves the hub idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.scan_done) |-> (result_reg.hub_mode == MODE_IDLE))
        else $error("scan reported done while hub not idle");

endmodule

// ===== hw/rtl/dscs_cfg.sv =====
// dscs_cfg: the three configuration registers and their write decode.
// Depends on dscs_pkg.
module dscs_cfg
    import dscs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit  <= RETRY_LIMIT_RST;
            cfg_reg.device_count <= DEVICE_COUNT_RST;
            cfg_reg.timeout_ms   <= TIMEOUT_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RETRY_LIMIT:  cfg_reg.retry_limit  <= cfg_data[RETRY_W-1:0];
                REG_DEVICE_COUNT: cfg_reg.device_count <= cfg_data[COUNT_W-1:0];
                REG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= cfg_data[TIMEOUT_W-1:0];
                default:          ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dscs_step.sv =====
// dscs_step: one sequencer step; next hub state and the result word for one item.
// Depends on dscs_pkg. Purely combinational.
module dscs_step
    import dscs_pkg::*;
(
    input  cfg_t       cfg,
    input  hub_state_t state_cur,
    input  item_t      item,
    output hub_state_t state_next,
    output result_t    result
);

    logic [COUNT_W-1:0]   eff_count;
    logic [TIMEOUT_W:0]   timer_sum;
    logic [TIMEOUT_W-1:0] timer_sat;
    logic                 timer_over;
    logic [COUNT_W-1:0]   send_index;
    logic [DEV_W-1:0]     new_sel;
    radio_ev_t            ev;

    assign eff_count  = (cfg.device_count > MAX_DEVICES_C) ? MAX_DEVICES_C : cfg.device_count;
    assign timer_sum  = {1'b0, state_cur.reply_timer} + (TIMEOUT_W+1)'(item.elapsed_ms);
    assign timer_sat  = timer_sum[TIMEOUT_W] ? TIMER_MAX : timer_sum[TIMEOUT_W-1:0];
    assign timer_over = timer_sat > cfg.timeout_ms;
    assign ev         = radio_ev_t'(item.radio_event);
    // index after the retry-limit skip in the send step
    assign send_index = (state_cur.retries >= cfg.retry_limit) ?
                        state_cur.scan_index + COUNT_W'(1) : state_cur.scan_index;
    assign new_sel    = ({1'b0, item.device_index} < eff_count) ?
                        item.device_index : state_cur.selected_target;

    always_comb
    begin
        state_next = state_cur;
        result     = '0;

        unique case (func_t'(item.func))
            FUNC_TICK:
            begin
                state_next.reply_timer = timer_sat;
                unique case (state_cur.mode)
                    MODE_SCAN:
                    begin
                        unique case (state_cur.scan_step)
                            SS_START:
                            begin
                                state_next.scan_index = '0;
                                state_next.retries    = '0;
                                state_next.responders = '0;
                                state_next.scan_step  = SS_SEND;
                            end
                            SS_SEND:
                            begin
                                state_next.scan_index = send_index;
                                if (state_cur.retries >= cfg.retry_limit)
                                    state_next.retries = '0;
                                if (send_index >= eff_count)
                                begin
                                    state_next.scan_step = SS_IDLE;
                                    state_next.mode      = MODE_IDLE;
                                    result.scan_done     = 1'b1;
                                end
                                else
                                begin
                                    result.send_valid      = 1'b1;
                                    result.send_target     = send_index[DEV_W-1:0];
                                    result.send_kind       = KIND_STATUS;
                                    state_next.scan_step   = SS_WAIT;
                                    state_next.reply_timer = '0;
                                end
                            end
                            SS_WAIT:
                            begin
                                if (ev == EV_RECV)
                                    state_next.scan_step = SS_FOUND;
                                else if (ev == EV_LOST)
                                    state_next.scan_step = SS_LOST;
                                if (timer_over)
                                begin
                                    result.timed_out     = 1'b1;
                                    state_next.scan_step = SS_LOST;
                                end
                            end
                            SS_LOST:
                            begin
                                if (state_cur.retries != RETRY_MAX)
                                    state_next.retries = state_cur.retries + RETRY_W'(1);
                                state_next.scan_step = SS_SEND;
                            end
                            SS_FOUND:
                            begin
                                if (!state_cur.scan_index[COUNT_W-1])
                                    state_next.responders = state_cur.responders |
                                        (MASK_W'(1) << state_cur.scan_index[DEV_W-1:0]);
                                state_next.scan_index = state_cur.scan_index + COUNT_W'(1);
                                state_next.retries    = '0;
                                state_next.scan_step  = SS_SEND;
                            end
                            default: ;
                        endcase
                    end
                    MODE_SEND:
                    begin
                        if (ev == EV_RECV)
                        begin
                            if (item.reply_is_status)
                            begin
                                result.status_received = 1'b1;
                                state_next.mode        = MODE_IDLE;
                            end
                        end
                        else
                        begin
                            if (ev == EV_LOST)
                                state_next.mode = MODE_IDLE;
                            if (timer_over)
                            begin
                                result.timed_out = 1'b1;
                                state_next.mode  = MODE_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_SCAN:
            begin
                if (state_cur.mode != MODE_IDLE)
                    result.busy_reject = 1'b1;
                else
                begin
                    state_next.mode      = MODE_SCAN;
                    state_next.scan_step = SS_START;
                end
            end
            FUNC_SEND:
            begin
                state_next.selected_target = new_sel;
                if (state_cur.mode != MODE_IDLE)
                    result.busy_reject = 1'b1;
                else
                begin
                    result.send_valid      = 1'b1;
                    result.send_target     = new_sel;
                    result.send_kind       = item.message_kind;
                    result.send_command    = item.message_kind ? 2'd0 : item.command_code;
                    state_next.mode        = MODE_SEND;
                    state_next.reply_timer = '0;
                end
            end
            default: ;  // spare function code: no state change
        endcase

        result.found_mask = state_next.responders;
        result.hub_mode   = state_next.mode;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for the radio hub scan and command sequencer.
// Depends on dscs_pkg and device_scan_and_command_sequencer; drives the input and
// register ports, predicts each result word and checks it against the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dscs_pkg::*;

    // Length of the long output hold used to back the block up to its input.
    localparam int HOLD_CYCLES = 60;
    localparam int ITEM_W      = $bits(item_t);

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Input channel.  Everything starts at a known value.
    logic                  in_valid        = 1'b0;
    logic                  in_ready;
    logic [1:0]            func            = '0;
    logic [2:0]            radio_event     = '0;
    logic [ELAPSED_W-1:0]  elapsed_ms      = '0;
    logic                  reply_is_status = 1'b0;
    logic [DEV_W-1:0]      device_index    = '0;
    logic                  message_kind    = 1'b0;
    logic [1:0]            command_code    = '0;

    // Output channel.
    logic                  out_valid;
    logic                  out_ready       = 1'b0;
    logic                  send_valid;
    logic [DEV_W-1:0]      send_target;
    logic                  send_kind;
    logic [1:0]            send_command;
    logic                  busy_reject;
    logic                  scan_done;
    logic [MASK_W-1:0]     found_mask;
    logic                  status_received;
    logic                  timed_out;
    logic [1:0]            hub_mode;

    // Register write port.
    logic                  cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    device_scan_and_command_sequencer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run control shared between the sender, the receiver and the tests.
    bit steady      = 1'b0;  // no random idling on either side
    bit hold_output = 1'b0;  // request one long receiver hold-off

    // Predicted result words, oldest first.
    result_t hub_results_due[$];

    int unsigned mismatches     = 0;
    int unsigned words_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned scans_seen     = 0;
    int unsigned replies_seen   = 0;
    int unsigned timeouts_seen  = 0;

    // ------------------------------------------------------------------
    // Predictor: own copy of the hub registers and state.
    // ------------------------------------------------------------------
    logic [RETRY_W-1:0]   reg_retry;
    logic [COUNT_W-1:0]   reg_count;
    logic [TIMEOUT_W-1:0] reg_timeout;

    hub_mode_t            exp_mode;
    scan_step_t           exp_step;
    logic [COUNT_W-1:0]   exp_index;
    logic [RETRY_W-1:0]   exp_retries;
    logic [TIMEOUT_W-1:0] exp_timer;
    logic [MASK_W-1:0]    exp_found;
    logic [DEV_W-1:0]     exp_target;

    task automatic hub_reset();
        reg_retry   = RETRY_LIMIT_RST;
        reg_count   = DEVICE_COUNT_RST;
        reg_timeout = TIMEOUT_MS_RST;
        exp_mode    = MODE_IDLE;
        exp_step    = SS_IDLE;
        exp_index   = '0;
        exp_retries = '0;
        exp_timer   = '0;
        exp_found   = '0;
        exp_target  = '0;
    endtask

    // One sequencer step: advances the predicted state, returns the result word.
    function automatic result_t hub_step(item_t w);
        result_t            r;
        logic [COUNT_W-1:0] limit;
        logic [TIMEOUT_W:0] sum;
        r     = '0;
        limit = (reg_count > MAX_DEVICES_C) ? MAX_DEVICES_C : reg_count;
        case (func_t'(w.func))
            FUNC_TICK:
            begin
                sum       = {1'b0, exp_timer} + (TIMEOUT_W+1)'(w.elapsed_ms);
                exp_timer = sum[TIMEOUT_W] ? TIMER_MAX : sum[TIMEOUT_W-1:0];
                if (exp_mode == MODE_SCAN)
                begin
                    case (exp_step)
                        SS_START:
                        begin
                            exp_index   = '0;
                            exp_retries = '0;
                            exp_found   = '0;
                            exp_step    = SS_SEND;
                        end
                        SS_SEND:
                        begin
                            if (exp_retries >= reg_retry)
                            begin
                                exp_index   = exp_index + COUNT_W'(1);
                                exp_retries = '0;
                            end
                            if (exp_index >= limit)
                            begin
                                exp_step    = SS_IDLE;
                                exp_mode    = MODE_IDLE;
                                r.scan_done = 1'b1;
                            end
                            else
                            begin
                                r.send_valid  = 1'b1;
                                r.send_target = exp_index[DEV_W-1:0];
                                r.send_kind   = KIND_STATUS;
                                exp_step      = SS_WAIT;
                                exp_timer     = '0;
                            end
                        end
                        SS_WAIT:
                        begin
                            if (w.radio_event == EV_RECV)
                                exp_step = SS_FOUND;
                            else if (w.radio_event == EV_LOST)
                                exp_step = SS_LOST;
                            if (exp_timer > reg_timeout)
                            begin
                                r.timed_out = 1'b1;
                                exp_step    = SS_LOST;
                            end
                        end
                        SS_LOST:
                        begin
                            if (exp_retries != RETRY_MAX)
                                exp_retries = exp_retries + RETRY_W'(1);
                            exp_step = SS_SEND;
                        end
                        SS_FOUND:
                        begin
                            if (exp_index < MAX_DEVICES_C)
                                exp_found[exp_index[DEV_W-1:0]] = 1'b1;
                            exp_index   = exp_index + COUNT_W'(1);
                            exp_retries = '0;
                            exp_step    = SS_SEND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (exp_mode == MODE_SEND)
                begin
                    if (w.radio_event == EV_RECV)
                    begin
                        // a non-status reply is ignored, timer not checked
                        if (w.reply_is_status)
                        begin
                            r.status_received = 1'b1;
                            exp_mode          = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        if (w.radio_event == EV_LOST)
                            exp_mode = MODE_IDLE;
                        if (exp_timer > reg_timeout)
                        begin
                            r.timed_out = 1'b1;
                            exp_mode    = MODE_IDLE;
                        end
                    end
                end
            end
            FUNC_SCAN:
            begin
                if (exp_mode != MODE_IDLE)
                    r.busy_reject = 1'b1;
                else
                begin
                    exp_mode = MODE_SCAN;
                    exp_step = SS_START;
                end
            end
            FUNC_SEND:
            begin
                // selection is taken even when the request is refused
                if ({1'b0, w.device_index} < limit)
                    exp_target = w.device_index;
                if (exp_mode != MODE_IDLE)
                    r.busy_reject = 1'b1;
                else
                begin
                    r.send_valid   = 1'b1;
                    r.send_target  = exp_target;
                    r.send_kind    = w.message_kind;
                    r.send_command = (w.message_kind == KIND_STATUS) ? 2'd0 : w.command_code;
                    exp_mode       = MODE_SEND;
                    exp_timer      = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.found_mask = exp_found;
        r.hub_mode   = exp_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Register writes: only called with nothing in flight.
    // ------------------------------------------------------------------
    task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_RETRY_LIMIT:  reg_retry   = val[RETRY_W-1:0];
            REG_DEVICE_COUNT: reg_count   = val[COUNT_W-1:0];
            REG_TIMEOUT_MS:   reg_timeout = val[TIMEOUT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_regs(int unsigned retry, int unsigned count, int unsigned tmo);
        set_reg(REG_RETRY_LIMIT, CFG_DATA_W'(retry));
        set_reg(REG_DEVICE_COUNT, CFG_DATA_W'(count));
        set_reg(REG_TIMEOUT_MS, CFG_DATA_W'(tmo));
    endtask

    // ------------------------------------------------------------------
    // Sender: offers one word, waits for it to be taken, books the prediction.
    // Valid stays high into the next word unless a gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_word(item_t w);
        result_t due;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= w.func;
        radio_event     <= w.radio_event;
        elapsed_ms      <= w.elapsed_ms;
        reply_is_status <= w.reply_is_status;
        device_index    <= w.device_index;
        message_kind    <= w.message_kind;
        command_code    <= w.command_code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due             = hub_step(w);
        hub_results_due = {hub_results_due, due};
        words_sent++;
    endtask

    // Let everything in flight come out.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (hub_results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t mk(func_t f, radio_ev_t ev, int unsigned el, bit st,
                                 int unsigned dev, bit kind, int unsigned cmd);
        item_t w;
        w.func            = f;
        w.radio_event     = ev;
        w.elapsed_ms      = ELAPSED_W'(el);
        w.reply_is_status = st;
        w.device_index    = DEV_W'(dev);
        w.message_kind    = kind;
        w.command_code    = 2'(cmd);
        return w;
    endfunction

    task automatic tick_word(radio_ev_t ev, int unsigned el, bit st);
        send_word(mk(FUNC_TICK, ev, el, st, 0, 1'b0, 0));
    endtask

    task automatic send_req(int unsigned dev, bit kind, int unsigned cmd);
        send_word(mk(FUNC_SEND, EV_NONE, 0, 1'b0, dev, kind, cmd));
    endtask

    // Tick shaped for a scan: mostly replies and losses, the odd stray request.
    function automatic item_t scan_tick_word();
        int unsigned r;
        radio_ev_t   ev;
        item_t       w;
        r = $urandom_range(0, 99);
        if (r < 35)
            ev = EV_RECV;
        else if (r < 60)
            ev = EV_LOST;
        else if (r < 80)
            ev = EV_NONE;
        else
            ev = radio_ev_t'($urandom_range(0, 7));
        w = mk(FUNC_TICK, ev,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
               $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
               $urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
            w.func = 2'($urandom_range(1, 3));
        return w;
    endfunction

    // Tick shaped for a send exchange.
    function automatic item_t reply_tick_word();
        int unsigned r;
        item_t       w;
        r = $urandom_range(0, 99);
        w = mk(FUNC_TICK, radio_ev_t'($urandom_range(0, 7)),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60),
               $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
               $urandom_range(0, 3));
        if (r < 35)
        begin
            w.radio_event     = EV_RECV;
            w.reply_is_status = 1'b1;
        end
        else if (r < 50)
        begin
            w.radio_event     = EV_RECV;
            w.reply_is_status = 1'b0;
        end
        else if (r < 65)
            w.radio_event = EV_LOST;
        return w;
    endfunction

    // Start a scan and keep ticking until the hub leaves scanning or the cap.
    task automatic run_scan(int unsigned cap);
        int unsigned n;
        send_word(mk(FUNC_SCAN, radio_ev_t'($urandom_range(0, 7)), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
                     $urandom_range(0, 3)));
        n = 0;
        while (exp_mode == MODE_SCAN && n < cap)
        begin
            send_word(scan_tick_word());
            n++;
        end
    endtask

    // One send request followed by ticks until the exchange closes.
    task automatic run_send(int unsigned cap);
        int unsigned n;
        send_word(mk(FUNC_SEND, radio_ev_t'($urandom_range(0, 7)), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
                     $urandom_range(0, 3)));
        n = 0;
        while (exp_mode == MODE_SEND && n < cap)
        begin
            send_word(reply_tick_word());
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold when a test asks for it.
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest booked prediction.
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic check_word(result_t got);
        result_t want;
        if (hub_results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result word %h", $realtime, got);
            return;
        end
        want = hub_results_due.pop_front();
        words_checked++;
        if (got.send_valid !== want.send_valid)
            note_mismatch("send_valid", want.send_valid, got.send_valid);
        if (got.send_target !== want.send_target)
            note_mismatch("send_target", want.send_target, got.send_target);
        if (got.send_kind !== want.send_kind)
            note_mismatch("send_kind", want.send_kind, got.send_kind);
        if (got.send_command !== want.send_command)
            note_mismatch("send_command", want.send_command, got.send_command);
        if (got.busy_reject !== want.busy_reject)
            note_mismatch("busy_reject", want.busy_reject, got.busy_reject);
        if (got.scan_done !== want.scan_done)
            note_mismatch("scan_done", want.scan_done, got.scan_done);
        if (got.found_mask !== want.found_mask)
            note_mismatch("found_mask", want.found_mask, got.found_mask);
        if (got.status_received !== want.status_received)
            note_mismatch("status_received", want.status_received, got.status_received);
        if (got.timed_out !== want.timed_out)
            note_mismatch("timed_out", want.timed_out, got.timed_out);
        if (got.hub_mode !== want.hub_mode)
            note_mismatch("hub_mode", want.hub_mode, got.hub_mode);
        if (want.scan_done)
            scans_seen++;
        if (want.status_received)
            replies_seen++;
        if (want.timed_out)
            timeouts_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_word(result_t'({send_valid, send_target, send_kind, send_command,
                                  busy_reject, scan_done, found_mask, status_received,
                                  timed_out, hub_mode}));
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked words at the reset settings (count 10, timeout 200).
    task automatic test_directed_words();
        tick_word(EV_NONE, 0, 1'b0);
        tick_word(EV_RSVD7, 255, 1'b1);
        send_word(mk(FUNC_SPARE, EV_RSVD7, 255, 1'b1, 15, 1'b1, 3)); // spare code: no effect
        send_req(15, KIND_COMMAND, 3);     // out of range: previous target kept
        tick_word(EV_RSVD5, 10, 1'b0);     // reserved event behaves as none
        tick_word(EV_BUSY, 20, 1'b1);
        tick_word(EV_SENT, 30, 1'b0);
        send_word(mk(FUNC_SCAN, EV_NONE, 0, 1'b0, 0, 1'b0, 0)); // refused, hub sending
        send_req(5, KIND_COMMAND, 1);      // refused, but selects 5
        tick_word(EV_RECV, 255, 1'b0);     // non-status reply: ignored, no timeout check
        tick_word(EV_RECV, 0, 1'b1);       // status reply closes the exchange
        send_req(12, KIND_STATUS, 2);      // status request: command forced to zero
        tick_word(EV_LOST, 255, 1'b0);     // loss together with timeout
        send_req(0, KIND_COMMAND, 0);
        tick_word(EV_RSVD6, 201, 1'b0);    // timeout on its own
        send_req(9, KIND_COMMAND, 2);      // highest index in range
        tick_word(EV_LOST, 0, 1'b0);
        send_req(10, KIND_STATUS, 0);      // lowest index out of range
        tick_word(EV_RECV, 200, 1'b1);
        drain();
    endtask

    // A full scan at the reset settings.
    task automatic test_scan_reset_settings();
        run_scan(600);
        drain();
    endtask

    // Scans at the register extremes.
    task automatic test_scan_extremes();
        set_regs(3, 0, 200);               // count zero: done without polling
        run_scan(20);
        drain();
        set_regs(0, 31, 200);              // count clamped, retry zero skips each index
        run_scan(100);
        drain();
        set_regs(1, 16, 0);                // every non-zero wait times out
        run_scan(400);
        drain();
        set_regs(15, 2, 65535);            // long retry runs on two devices
        run_scan(400);
        drain();
        set_reg(REG_UNUSED, 16'hFFFF);     // spare index: nothing changes
        set_regs(2, 1, 100);
        run_scan(100);
        drain();
    endtask

    // Long output hold while words keep coming, so the input side backs up.
    task automatic test_output_hold();
        set_regs(3, 10, 200);
        steady      = 1'b1;
        hold_output = 1'b1;
        repeat (4)
            run_send(3);
        run_scan(8);
        drain();
        steady = 1'b0;
    endtask

    // Random traffic: mostly well-formed exchanges, some noise; last phase steady.
    task automatic test_random_traffic();
        int unsigned phase_start;
        int unsigned pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 4)
                steady = 1'b1;
            set_regs($urandom_range(0, 4),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
                     ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 65535)
                                                 : $urandom_range(20, 300));
            phase_start = words_sent;
            while (words_sent - phase_start < 30)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    run_scan(40);
                else if (pick < 8)
                    run_send(10);
                else
                    repeat ($urandom_range(1, 4))
                        send_word(item_t'(ITEM_W'($urandom)));
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int unsigned settle;
        hub_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_words();
        test_scan_reset_settings();
        test_scan_extremes();
        test_output_hold();
        test_random_traffic();

        in_valid <= 1'b0;
        settle = 0;
        while (hub_results_due.size() != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (8) @(posedge clk);
        if (hub_results_due.size() != 0)
        begin
            mismatches++;
            $display("%0d result words never arrived", hub_results_due.size());
        end

        $display("Run covered %0d input words and %0d result words over several settings:",
                 words_sent, words_checked);
        $display("%0d scans completed, %0d status replies, %0d timeouts; %0d mismatches.",
                 scans_seen, replies_seen, timeouts_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dscs_pkg.sv
hw/rtl/dscs_cfg.sv
hw/rtl/dscs_step.sv
hw/rtl/device_scan_and_command_sequencer.sv
tb/sv/tb_top.sv
